[src/tctb_pkg.sv]
// Shared types, op codes and constants for the text cell terminal buffer.
package tctb_pkg;

    // Op codes of a request
    localparam logic [2:0] OP_PUT_CHAR   = 3'd0;
    localparam logic [2:0] OP_SET_CURSOR = 3'd1;
    localparam logic [2:0] OP_CLEAR      = 3'd2;
    localparam logic [2:0] OP_READ_CELL  = 3'd3;
    localparam logic [2:0] OP_CAP_BEGIN  = 3'd4;
    localparam logic [2:0] OP_CAP_END    = 3'd5;

    localparam logic [7:0] NL_CHAR    = 8'd10;
    localparam logic [7:0] CR_CHAR    = 8'd13;
    localparam logic [7:0] BLANK_CHAR = 8'd32;

    // Capture buffer size limit in bytes
    localparam int CAPTURE_DEPTH = 4096;

    typedef struct packed {
        logic [2:0]         op;
        logic [7:0]         ch;
        logic signed [15:0] col;
        logic signed [15:0] row;
        logic [11:0]        capture_max;
    } req_t;

    typedef struct packed {
        logic        cap_valid;
        logic [11:0] cap_index;
        logic [7:0]  cap_byte;
        logic [7:0]  cell_char;
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [11:0] captured_len;
        logic        last;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_RES1,
        ST_RES2
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic sweep_step;
        logic out_load1;
        logic out_load2;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_sweep;
        logic sweep_last;
        logic two_results;
        logic out_free;
    } dp_status_t;

endpackage

[src/tctb_ctrl.sv]
// Controller state machine for the text cell terminal buffer.
module tctb_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  tctb_pkg::dp_status_t   st,
    output tctb_pkg::ctrl_cmd_t    cmd
);
    import tctb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                // blank the whole store after reset
                cmd.sweep_step = 1'b1;
                if (st.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = st.need_sweep ? ST_SWEEP : ST_RES1;
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (st.sweep_last)
                begin
                    state_next = ST_RES1;
                end
            end
            ST_RES1:
            begin
                if (st.out_free)
                begin
                    cmd.out_load1 = 1'b1;
                    state_next    = st.two_results ? ST_RES2 : ST_IDLE;
                end
            end
            ST_RES2:
            begin
                if (st.out_free)
                begin
                    cmd.out_load2 = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

[src/tctb_datapath.sv]
// Datapath: cursor, scroll base, capture state, cell memory and result register.
module tctb_datapath #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tctb_pkg::req_t         req,
    input  tctb_pkg::ctrl_cmd_t    cmd,
    output tctb_pkg::dp_status_t   st,
    output tctb_pkg::rsp_t         rsp,
    output logic                   rsp_valid,
    input  logic                   rsp_ready
);
    import tctb_pkg::*;

    localparam int TOTAL  = ROWS * COLS;
    localparam int ADDR_W = $clog2(TOTAL);
    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam logic [COL_W-1:0]  COL_MAX = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0]  ROW_MAX = ROW_W'(ROWS - 1);
    localparam logic [ROW_W:0]    ROWS_X  = (ROW_W + 1)'(ROWS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TOTAL - 1);

    // logical row plus scroll base, wrapped into the ring of rows
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                   input logic [ROW_W-1:0] b);
        logic [ROW_W:0] s;
        s = {1'b0, r} + {1'b0, b};
        if (s >= ROWS_X)
        begin
            s = s - ROWS_X;
        end
        return s[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c);
    endfunction

    req_t              req_reg;
    logic [COL_W-1:0]  x_reg, x_next;
    logic [ROW_W-1:0]  y_reg, y_next;
    logic [ROW_W-1:0]  base_reg, base_next;
    logic              active_reg, active_next;
    logic [11:0]       limit_reg, limit_next;
    logic [11:0]       count_reg, count_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0] sweep_end_reg, sweep_end_next;
    logic              res_valid_reg, res_valid_next;
    logic [11:0]       res_idx_reg, res_idx_next;
    logic [7:0]        res_byte_reg, res_byte_next;
    logic              two_reg, two_next;
    logic              is_read_reg, is_read_next;
    logic [7:0]        rd_data_reg;
    rsp_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic [7:0]        mem [TOTAL];

    logic              need_sweep;
    logic              char_wr;
    logic [ADDR_W-1:0] char_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [COL_W-1:0]  col_clamp;
    logic [ROW_W-1:0]  row_clamp;
    logic [11:0]       limit_sat;
    logic [11:0]       end_count;
    logic              advance;
    logic              mem_wr;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [7:0]        mem_wr_data;

    always_comb
    begin
        if (req_reg.col[15])
        begin
            col_clamp = '0;
        end
        else if (req_reg.col[14:0] > 15'(COLS - 1))
        begin
            col_clamp = COL_MAX;
        end
        else
        begin
            col_clamp = req_reg.col[COL_W-1:0];
        end
        if (req_reg.row[15])
        begin
            row_clamp = '0;
        end
        else if (req_reg.row[14:0] > 15'(ROWS - 1))
        begin
            row_clamp = ROW_MAX;
        end
        else
        begin
            row_clamp = req_reg.row[ROW_W-1:0];
        end
        limit_sat = (32'(req_reg.capture_max) > CAPTURE_DEPTH) ? 12'(CAPTURE_DEPTH)
                                                               : req_reg.capture_max;
        end_count = (count_reg >= limit_reg) ? (limit_reg - 12'd1) : count_reg;
    end

    // execute one request
    always_comb
    begin
        x_next          = x_reg;
        y_next          = y_reg;
        base_next       = base_reg;
        active_next     = active_reg;
        limit_next      = limit_reg;
        count_next      = count_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_end_next  = sweep_end_reg;
        res_valid_next  = res_valid_reg;
        res_idx_next    = res_idx_reg;
        res_byte_next   = res_byte_reg;
        two_next        = two_reg;
        is_read_next    = is_read_reg;
        need_sweep      = 1'b0;
        char_wr         = 1'b0;
        char_addr       = cell_addr(phys_row(y_reg, base_reg), x_reg);
        rd_en           = 1'b0;
        rd_addr         = cell_addr(phys_row(row_clamp, base_reg), col_clamp);
        advance         = 1'b0;

        if (cmd.sweep_step)
        begin
            sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
        end

        if (cmd.exec)
        begin
            res_valid_next = 1'b0;
            res_idx_next   = '0;
            res_byte_next  = '0;
            two_next       = 1'b0;
            is_read_next   = 1'b0;
            case (req_reg.op)
                OP_PUT_CHAR:
                begin
                    if (active_reg)
                    begin
                        if ((limit_reg != '0) &&
                            ({1'b0, count_reg} + 13'd1 < {1'b0, limit_reg}))
                        begin
                            two_next       = 1'b1;
                            res_valid_next = 1'b1;
                            res_idx_next   = count_reg;
                            res_byte_next  = req_reg.ch;
                            count_next     = count_reg + 12'd1;
                        end
                    end
                    else if (req_reg.ch == NL_CHAR)
                    begin
                        advance = 1'b1;
                    end
                    else if (req_reg.ch == CR_CHAR)
                    begin
                        x_next = '0;
                    end
                    else
                    begin
                        char_wr = 1'b1;
                        if (x_reg == COL_MAX)
                        begin
                            advance = 1'b1;
                        end
                        else
                        begin
                            x_next = x_reg + COL_W'(1);
                        end
                    end
                    if (advance)
                    begin
                        x_next = '0;
                        if (y_reg == ROW_MAX)
                        begin
                            // scroll: old top row becomes the new bottom, blanked
                            base_next       = (base_reg == ROW_MAX) ? '0
                                                                    : base_reg + ROW_W'(1);
                            sweep_addr_next = cell_addr(base_reg, '0);
                            sweep_end_next  = cell_addr(base_reg, COL_MAX);
                            need_sweep      = 1'b1;
                        end
                        else
                        begin
                            y_next = y_reg + ROW_W'(1);
                        end
                    end
                end
                OP_SET_CURSOR:
                begin
                    x_next = col_clamp;
                    y_next = row_clamp;
                end
                OP_CLEAR:
                begin
                    x_next          = '0;
                    y_next          = '0;
                    base_next       = '0;
                    sweep_addr_next = '0;
                    sweep_end_next  = LAST_ADDR;
                    need_sweep      = 1'b1;
                end
                OP_READ_CELL:
                begin
                    rd_en        = 1'b1;
                    is_read_next = 1'b1;
                end
                OP_CAP_BEGIN:
                begin
                    active_next = 1'b1;
                    limit_next  = limit_sat;
                    count_next  = '0;
                    if (limit_sat != '0)
                    begin
                        res_valid_next = 1'b1;
                    end
                end
                OP_CAP_END:
                begin
                    if (active_reg && (limit_reg != '0))
                    begin
                        count_next     = end_count;
                        res_valid_next = 1'b1;
                        res_idx_next   = end_count;
                    end
                    active_next = 1'b0;
                    limit_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // result register
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load1)
        begin
            out_next.cap_valid    = res_valid_reg;
            out_next.cap_index    = res_idx_reg;
            out_next.cap_byte     = res_byte_reg;
            out_next.cell_char    = is_read_reg ? rd_data_reg : 8'd0;
            out_next.cursor_col   = 7'(x_reg);
            out_next.cursor_row   = 5'(y_reg);
            out_next.captured_len = count_reg;
            out_next.last         = !two_reg;
            out_valid_next        = 1'b1;
        end
        else if (cmd.out_load2)
        begin
            // terminator after a captured byte
            out_next.cap_valid    = 1'b1;
            out_next.cap_index    = res_idx_reg + 12'd1;
            out_next.cap_byte     = 8'd0;
            out_next.cell_char    = 8'd0;
            out_next.cursor_col   = 7'(x_reg);
            out_next.cursor_row   = 5'(y_reg);
            out_next.captured_len = count_reg;
            out_next.last         = 1'b1;
            out_valid_next        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg          <= '0;
            y_reg          <= '0;
            base_reg       <= '0;
            active_reg     <= 1'b0;
            limit_reg      <= '0;
            count_reg      <= '0;
            sweep_addr_reg <= '0;
            sweep_end_reg  <= LAST_ADDR;
            res_valid_reg  <= 1'b0;
            two_reg        <= 1'b0;
            is_read_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            x_reg          <= x_next;
            y_reg          <= y_next;
            base_reg       <= base_next;
            active_reg     <= active_next;
            limit_reg      <= limit_next;
            count_reg      <= count_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_end_reg  <= sweep_end_next;
            res_valid_reg  <= res_valid_next;
            two_reg        <= two_next;
            is_read_reg    <= is_read_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        res_idx_reg  <= res_idx_next;
        res_byte_reg <= res_byte_next;
        out_reg      <= out_next;
    end

    // cell memory: one write port, one registered read port
    assign mem_wr      = cmd.sweep_step || char_wr;
    assign mem_wr_addr = cmd.sweep_step ? sweep_addr_reg : char_addr;
    assign mem_wr_data = cmd.sweep_step ? BLANK_CHAR : req_reg.ch;

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign st.need_sweep  = need_sweep;
    assign st.sweep_last  = (sweep_addr_reg == sweep_end_reg);
    assign st.two_results = two_reg;
    assign st.out_free    = !out_valid_reg || rsp_ready;

    assign rsp       = out_reg;
    assign rsp_valid = out_valid_reg;

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (x_reg <= COL_MAX) && (y_reg <= ROW_MAX) && (base_reg <= ROW_MAX))
        else $error("cursor or scroll base out of range");

    a_count_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && (limit_reg != '0)) |-> (count_reg < limit_reg))
        else $error("capture count reached limit while active");

    a_idle_no_limit: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (limit_reg == '0))
        else $error("capture limit kept after capture ended");

    a_terminator_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.last && rsp_ready) |=>
        (out_valid_reg && out_reg.last && out_reg.cap_valid && out_reg.cap_byte == 8'd0))
        else $error("captured byte not followed by terminator");

endmodule

[src/text_cell_terminal_buffer.sv]
// Top level of the text cell terminal buffer: controller plus datapath.
//
// Usage: a request (op, ch, col, row, capture_max) comes in on req with
// req_valid/req_ready; results leave on rsp with rsp_valid/rsp_ready.
// A put char that captures a byte gives two results (byte, then terminator);
// every other request gives exactly one, with rsp.last set on the final one.
// The cells live in a ROWS x COLS byte memory addressed through a rotating
// row base, so a scroll only moves the base and blanks one row.
// Per request the sequencer loads it, executes it, then hands off its
//   result(s); a put char that scrolls adds a row blanking pass and a
//   clear adds a whole-store blanking pass before the hand-off.
// Reset: cursor, scroll base and capture state clear; then a blanking pass
// fills the memory with spaces, and req_ready stays low until it is done.
// Receiver stall: results sit in an output register; the next request is
// taken while one waits, and processing pauses only when a new result has
// to be loaded and the register is still full.
module text_cell_terminal_buffer #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  tctb_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output tctb_pkg::rsp_t  rsp
);
    import tctb_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t st;

    // sequencer: init sweep, execute, blank sweep, result hand-off
    tctb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .st        (st),
        .cmd       (cmd)
    );

    // cursor, capture, cell memory and output register
    tctb_datapath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .st        (st),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready)
    );

endmodule

[sim/tctb_scoreboard.sv]
// Scoreboard for the terminal buffer: cell/cursor/capture predictor plus result checker.
package tctb_scoreboard_pkg;
    import tctb_pkg::*;

    localparam int SCR_COLS = 80;
    localparam int SCR_ROWS = 25;
    localparam int MAX_PRINTED = 40;

    class term_scoreboard;
        logic [7:0] cells [SCR_ROWS*SCR_COLS];
        int         cur_x;
        int         cur_y;
        bit         cap_on;
        int         cap_lim;
        int         cap_cnt;
        rsp_t       pending [$];

        int errors;
        int checked;
        int requests;
        int scrolls;
        int reads;
        int cap_bytes;

        function new();
            blank_all();
            cur_x   = 0;
            cur_y   = 0;
            cap_on  = 1'b0;
            cap_lim = 0;
            cap_cnt = 0;
        endfunction

        function void blank_all();
            int i;
            for (i = 0; i < SCR_ROWS*SCR_COLS; i++)
                cells[i] = BLANK_CHAR;
        endfunction

        function int clamp(logic signed [15:0] v, int hi);
            int s;
            s = v;
            if (s < 0)
                return 0;
            if (s > hi)
                return hi;
            return s;
        endfunction

        // newline or wrap; scroll everything up at the bottom row
        function void next_row();
            int i;
            cur_x = 0;
            cur_y++;
            if (cur_y >= SCR_ROWS)
            begin
                for (i = 0; i < (SCR_ROWS-1)*SCR_COLS; i++)
                    cells[i] = cells[i+SCR_COLS];
                for (i = (SCR_ROWS-1)*SCR_COLS; i < SCR_ROWS*SCR_COLS; i++)
                    cells[i] = BLANK_CHAR;
                cur_y = SCR_ROWS - 1;
                scrolls++;
            end
        endfunction

        function void add(bit v, int idx, logic [7:0] b, logic [7:0] cell_val, bit lst);
            rsp_t r;
            r.cap_valid    = v;
            r.cap_index    = 12'(idx);
            r.cap_byte     = b;
            r.cell_char    = cell_val;
            r.cursor_col   = 7'(cur_x);
            r.cursor_row   = 5'(cur_y);
            r.captured_len = 12'(cap_cnt);
            r.last         = lst;
            pending.push_back(r);
        endfunction

        function void note_request(req_t q);
            int cx;
            int cy;
            requests++;
            case (q.op)
                OP_PUT_CHAR:
                begin
                    if (cap_on)
                    begin
                        if (cap_lim > 0 && cap_cnt + 1 < cap_lim)
                        begin
                            cap_cnt++;
                            cap_bytes++;
                            add(1'b1, cap_cnt - 1, q.ch, 8'h00, 1'b0);
                            add(1'b1, cap_cnt, 8'h00, 8'h00, 1'b1);
                            return;
                        end
                    end
                    else if (q.ch == NL_CHAR)
                    begin
                        next_row();
                    end
                    else if (q.ch == CR_CHAR)
                    begin
                        cur_x = 0;
                    end
                    else
                    begin
                        cells[cur_y*SCR_COLS + cur_x] = q.ch;
                        cur_x++;
                        if (cur_x >= SCR_COLS)
                            next_row();
                    end
                end
                OP_SET_CURSOR:
                begin
                    cur_x = clamp(q.col, SCR_COLS - 1);
                    cur_y = clamp(q.row, SCR_ROWS - 1);
                end
                OP_CLEAR:
                begin
                    blank_all();
                    cur_x = 0;
                    cur_y = 0;
                end
                OP_READ_CELL:
                begin
                    cx = clamp(q.col, SCR_COLS - 1);
                    cy = clamp(q.row, SCR_ROWS - 1);
                    reads++;
                    add(1'b0, 0, 8'h00, cells[cy*SCR_COLS + cx], 1'b1);
                    return;
                end
                OP_CAP_BEGIN:
                begin
                    cap_on  = 1'b1;
                    cap_lim = (int'(q.capture_max) > CAPTURE_DEPTH) ?
                              CAPTURE_DEPTH : int'(q.capture_max);
                    cap_cnt = 0;
                    if (cap_lim > 0)
                    begin
                        add(1'b1, 0, 8'h00, 8'h00, 1'b1);
                        return;
                    end
                end
                OP_CAP_END:
                begin
                    if (cap_on && cap_lim > 0)
                    begin
                        if (cap_cnt >= cap_lim)
                            cap_cnt = cap_lim - 1;
                        cap_on  = 1'b0;
                        cap_lim = 0;
                        add(1'b1, cap_cnt, 8'h00, 8'h00, 1'b1);
                        return;
                    end
                    cap_on  = 1'b0;
                    cap_lim = 0;
                end
                default: ;
            endcase
            add(1'b0, 0, 8'h00, 8'h00, 1'b1);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("MISMATCH: %s", msg);
        endtask

        task check_field(string name, logic [11:0] got, logic [11:0] want);
            if (got !== want)
                report($sformatf("result %0d: %s is %0h, expected %0h",
                                 checked, name, got, want));
        endtask

        task check_result(rsp_t got);
            rsp_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("result %h arrived with nothing pending", got));
                return;
            end
            want = pending.pop_front();
            checked++;
            check_field("cap_valid", 12'(got.cap_valid), 12'(want.cap_valid));
            check_field("cap_index", got.cap_index, want.cap_index);
            check_field("cap_byte", 12'(got.cap_byte), 12'(want.cap_byte));
            check_field("cell_char", 12'(got.cell_char), 12'(want.cell_char));
            check_field("cursor_col", 12'(got.cursor_col), 12'(want.cursor_col));
            check_field("cursor_row", 12'(got.cursor_row), 12'(want.cursor_row));
            check_field("captured_len", got.captured_len, want.captured_len);
            check_field("last", 12'(got.last), 12'(want.last));
        endtask
    endclass

endpackage

[sim/tb.sv]
// Testbench top for the text cell terminal buffer.
module tb;
    import tctb_pkg::*;
    import tctb_scoreboard_pkg::*;

    // Op codes the block ignores; used as noise
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int ITEM_TARGET = 1750;
    localparam int REQ_W = $bits(req_t);

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    term_scoreboard sb = new();

    int accepted_cnt;   // requests that do real work (spare op codes excluded)
    int burst_left;
    bit drained_mid;

    // receiver stall pattern state
    int stall_left;
    int rx_mode;
    int rx_cycle;

    text_cell_terminal_buffer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop for a run that hangs. It leaves room for the slowest legal run
    // (reset blanking, a handful of full clears, a scroll on most put chars,
    // long receiver stalls).
    initial
    begin
        #15000000;
        $display("text_cell_terminal_buffer test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: check every accepted result against the oldest
    // expectation, then pick rsp_ready for the next edge. The modes are
    // always ready, coin flip, mostly stalled, or long stall bursts, so
    // stalls land on every phase of the sequencer.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_result(rsp);
        rx_cycle++;
        if (rx_cycle % 150 == 0)
            rx_mode = $urandom_range(0, 3);
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: rsp_ready <= 1'b1;
                1: rsp_ready <= 1'($urandom_range(0, 1));
                2: rsp_ready <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        stall_left = $urandom_range(3, 15);
                        rsp_ready <= 1'b0;
                    end
                    else
                        rsp_ready <= 1'b1;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Present one request, hold it until taken, log it with the scoreboard.
    // Bursts of 1..16 requests; between bursts req_valid drops for a gap, or
    // no gap at all about a third of the time so back-to-back stretches occur.
    task automatic issue(input req_t r);
        int gap;
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(r);
        if (r.op <= OP_CAP_END)
            accepted_cnt++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Hold off until every expected result has come back. The loop waits on a
    // clock edge before it tests, so valid is never dropped and raised in the same step.
    task automatic wait_idle();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending.size() != 0);
    endtask

    function automatic req_t mk(logic [2:0] op, logic [7:0] ch, logic signed [15:0] col,
                                logic signed [15:0] row, logic [11:0] cmax);
        req_t r;
        r.op          = op;
        r.ch          = ch;
        r.col         = col;
        r.row         = row;
        r.capture_max = cmax;
        return r;
    endfunction

    // Fields an op does not use still get random values so all bits toggle.
    task automatic put(input logic [7:0] c);
        issue(mk(OP_PUT_CHAR, c, 16'($urandom), 16'($urandom), 12'($urandom)));
    endtask

    task automatic move_to(input logic signed [15:0] c, input logic signed [15:0] r);
        issue(mk(OP_SET_CURSOR, 8'($urandom), c, r, 12'($urandom)));
    endtask

    task automatic read_at(input logic signed [15:0] c, input logic signed [15:0] r);
        issue(mk(OP_READ_CELL, 8'($urandom), c, r, 12'($urandom)));
    endtask

    task automatic cap_begin(input logic [11:0] m);
        issue(mk(OP_CAP_BEGIN, 8'($urandom), 16'($urandom), 16'($urandom), m));
    endtask

    task automatic cap_end();
        issue(mk(OP_CAP_END, 8'($urandom), 16'($urandom), 16'($urandom), 12'($urandom)));
    endtask

    // Text-like bytes: mostly printable, with newlines, returns and raw bytes.
    function automatic logic [7:0] text_char();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return NL_CHAR;
        if (sel < 12)
            return CR_CHAR;
        if (sel < 72)
            return 8'($urandom_range(32, 126));
        return 8'($urandom);
    endfunction

    // Coordinate: mostly in range, sometimes at or past the edges, sometimes wild.
    function automatic logic signed [15:0] pick_coord(int hi);
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 15)
            return 16'($urandom_range(0, hi));
        if (sel < 17)
            return 16'($urandom);
        if (sel == 17)
            return -16'sd1;
        if (sel == 18)
            return 16'(hi + 1);
        return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endfunction

    // Capture size: zero, one, tiny sizes that fill up fast, or anything.
    function automatic logic [11:0] pick_cap_size();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 3)
            return 12'd0;
        if (sel < 6)
            return 12'd1;
        if (sel < 9)
            return 12'($urandom_range(2, 5));
        if (sel < 16)
            return 12'($urandom_range(6, 40));
        return 12'($urandom);
    endfunction

    initial
    begin
        int kind;
        int n;
        int i;
        req_t r;

        burst_left = 4;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // ---------------- directed part ----------------
        // clamp of the most negative and most positive coordinates
        read_at(16'sh8000, 16'sh8000);
        read_at(16'sh7fff, 16'sh7fff);
        // extreme bytes, then carriage return and newline
        put("A");
        put(8'h00);
        put(8'hff);
        put(CR_CHAR);
        put(NL_CHAR);
        read_at(16'sd0, 16'sd0);
        // write in the bottom-right cell: wrap past the last column scrolls
        move_to(16'sd79, 16'sd24);
        put("Z");
        read_at(16'sd79, 16'sd23);
        // newline on the bottom row scrolls again
        put(NL_CHAR);
        move_to(-16'sd1, 16'sh7fff);
        // zero-size capture: put char gives no write, end gives no write
        cap_begin(12'd0);
        put("q");
        cap_end();
        // size 3: two bytes fit, the third hits the saturation point
        cap_begin(12'd3);
        put("a");
        put("b");
        put("c");
        cap_end();
        // end with no capture open
        cap_end();
        // size 1: only the terminator fits
        cap_begin(12'd1);
        put("x");
        cap_end();
        issue(mk(OP_SPARE_6, 8'($urandom), 16'($urandom), 16'($urandom), 12'($urandom)));
        issue(mk(OP_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom), 12'($urandom)));
        read_at(16'sd1, 16'sd0);

        // let the pipe empty out completely before the random part
        wait_idle();

        // ---------------- random part ----------------
        while (accepted_cnt < ITEM_TARGET)
        begin
            if (!drained_mid && accepted_cnt >= ITEM_TARGET / 2)
            begin
                wait_idle();
                drained_mid = 1'b1;
            end
            kind = $urandom_range(0, 199);
            if (kind < 80)
            begin
                // run of text at the cursor
                n = $urandom_range(5, 40);
                for (i = 0; i < n; i++)
                    put(text_char());
            end
            else if (kind < 100)
            begin
                // jump, often near the bottom-right corner so wraps scroll
                if ($urandom_range(0, 1))
                    move_to(16'($urandom_range(70, 79)), 16'sd24);
                else
                    move_to(pick_coord(79), pick_coord(24));
                n = $urandom_range(1, 12);
                for (i = 0; i < n; i++)
                    put(text_char());
            end
            else if (kind < 140)
            begin
                // read back, mostly around the cursor where text lives
                n = $urandom_range(2, 8);
                for (i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 1))
                        read_at(16'($urandom_range(0, 79)),
                                16'(sb.cur_y - $urandom_range(0, 1)));
                    else
                        read_at(pick_coord(79), pick_coord(24));
                end
            end
            else if (kind < 180)
            begin
                // capture session; sometimes left open or closed twice
                cap_begin(pick_cap_size());
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) :
                                                   $urandom_range(0, 12);
                for (i = 0; i < n; i++)
                    put(text_char());
                kind = $urandom_range(0, 19);
                if (kind < 17)
                    cap_end();
                else if (kind < 19)
                begin
                    cap_end();
                    cap_end();
                end
            end
            else if (kind < 197)
            begin
                // noise: spare op codes, stray ends, fully random requests
                r = req_t'(REQ_W'({$urandom, $urandom}));
                case ($urandom_range(0, 3))
                    0: r.op = OP_SPARE_6;
                    1: r.op = OP_SPARE_7;
                    2: r.op = OP_CAP_END;
                    default:
                        if (r.op == OP_CLEAR)
                            r.op = OP_READ_CELL;
                endcase
                issue(r);
            end
            else
            begin
                // full clear is a long blanking pass, so keep it rare
                issue(mk(OP_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom),
                         12'($urandom)));
            end
        end

        // drain, then a quiet window to catch any stray result
        wait_idle();
        repeat (100) @(posedge clk);

        $display("Run covered %0d requests and %0d checked results: %0d cell reads, %0d scrolls.",
                 sb.requests, sb.checked, sb.reads, sb.scrolls);
        $display("Capture wrote %0d bytes; %0d mismatches seen.", sb.cap_bytes, sb.errors);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending.size()));
        if (sb.errors == 0)
            $display("text_cell_terminal_buffer test passed");
        else
            $display("text_cell_terminal_buffer test failed");
        $finish;
    end

endmodule

[text_cell_terminal_buffer.f]
src/tctb_pkg.sv
src/tctb_ctrl.sv
src/tctb_datapath.sv
src/text_cell_terminal_buffer.sv
sim/tctb_scoreboard.sv
sim/tb.sv
